@@ rtl/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg: shared types for the ordered list engine
// Operation and status codes, the control word that steers the list cells,
// and the layout of one result word.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 11;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_END   = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_END   = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_SEARCH    = 3'd6,
      OP_UPDATE    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_kind_type;

   // idx: insert or delete slot, or the last occupied slot while rotating
   // fill: value to insert, or the value wrapped to the tail while rotating
   typedef struct packed {
      cell_kind_type           kind;
      logic [POS_W-1:0]        idx;
      logic [DATA_W-1:0]       fill;
   } cell_ctrl_type;

   typedef struct packed {
      logic [POS_W-1:0]        count;
      logic [POS_W-1:0]        fpos;
      status_type              status;
   } result_type;

endpackage

@@ rtl/ole_cell.sv @@
// ----------------------------------------------------------------------------
// ole_cell: one slot of the list
// Holds one entry and, under the shared control word, keeps it, takes the
// left or right neighbor's entry, or loads the fill value.
// ----------------------------------------------------------------------------
module ole_cell
   import ole_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_data,
   input  logic [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]   data
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.kind)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_INSERT: begin
            if (MY_IDX == ctrl.idx) begin
               data_in = ctrl.fill;
            end else if (MY_IDX > ctrl.idx) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= ctrl.idx) begin
               data_in = right_data;
            end
         end
         CELL_ROTATE: begin
            // close the ring: the tail takes the fill value, the head's entry or its new value
            if (MY_IDX == ctrl.idx) begin
               data_in = ctrl.fill;
            end else if (MY_IDX < ctrl.idx) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ rtl/ordered_list_engine.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine: ordered list of signed 32-bit values
// Insert, delete, search and update on a list held in a row of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry per cell, head in
// cell 0. Inserts and deletes shift the cells at and beyond the slot all
// at once, and those words, like every word that fails a check, need no
// scan. Search and update rotate the occupied cells as a ring one step per
// cycle past a single comparator on cell 0, and always turn the ring a full
// lap to restore order. The result is registered into the output stage
// after the last step, and a two-word output stage lets the next request
// in while a result waits to be taken.
module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [31:0] position, [63:32] value, [95:64] new_value
   input  logic [95:0]   req_tdata,
   // [2:0] operation
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [2:0] status, [13:3] found_position, [24:14] entry_count, rest zero
   output logic [31:0]   rsp_tdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   fpos_ff, fpos_in;
   logic               hit_ff, hit_in;
   logic               upd_ff;
   logic [DATA_W-1:0]  val_ff, nval_ff;
   logic               out_valid_ff, out_valid_in;
   logic               spare_valid_ff, spare_valid_in;
   result_type         out_ff, out_in;
   result_type         spare_ff, spare_in;

   logic [DATA_W-1:0]  cell_q [CAPACITY];
   cell_ctrl_type      ctrl;
   cell_ctrl_type      dec_ctrl;
   result_type         dec_res;
   result_type         new_res;
   logic               new_valid;
   logic               dec_scan;
   logic [CNT_W-1:0]   dec_count;

   op_type             op;
   logic [DATA_W-1:0]  pos, val, nval;
   logic [31:0]        cnt32;
   logic               pos_ge1, ins_pos_ok, del_pos_ok, full, empty;
   logic [POS_W-1:0]   pos_idx, cnt_idx, last_idx;
   logic               accept, take;
   logic               match, scan_hit, scan_last;

   assign op    = op_type'(req_tuser);
   assign pos   = req_tdata[31:0];
   assign val   = req_tdata[63:32];
   assign nval  = req_tdata[95:64];

   assign req_tready = !reset && (state_ff == IDLE) && !spare_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   assign cnt32      = 32'(count_ff);
   assign pos_ge1    = !pos[31] && (pos != '0);
   assign ins_pos_ok = pos_ge1 && (pos <= cnt32 + 32'd1);
   assign del_pos_ok = pos_ge1 && (pos <= cnt32);
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;
   assign pos_idx    = POS_W'(pos - 32'd1);
   assign cnt_idx    = POS_W'(count_ff);
   assign last_idx   = POS_W'(count_ff - CNT_W'(1));

   // decode one request word
   always_comb begin
      dec_ctrl.kind = CELL_HOLD;
      dec_ctrl.idx  = '0;
      dec_ctrl.fill = val;
      dec_count     = count_ff;
      dec_scan      = 1'b0;
      dec_res.status = ST_OK;
      dec_res.fpos   = '0;
      unique case (op)
         OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
            if (op == OP_INS_POS && !ins_pos_ok) begin
               dec_res.status = ST_BADPOS;
            end else if (full) begin
               dec_res.status = ST_FULL;
            end else begin
               dec_ctrl.kind = CELL_INSERT;
               priority case (op)
                  OP_INS_FRONT: dec_ctrl.idx = '0;
                  OP_INS_END:   dec_ctrl.idx = cnt_idx;
                  default:      dec_ctrl.idx = pos_idx;
               endcase
               dec_count = count_ff + CNT_W'(1);
            end
         end
         OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
            if (empty) begin
               dec_res.status = ST_EMPTY;
            end else if (op == OP_DEL_POS && !del_pos_ok) begin
               dec_res.status = ST_BADPOS;
            end else begin
               dec_ctrl.kind = CELL_DELETE;
               priority case (op)
                  OP_DEL_FRONT: dec_ctrl.idx = '0;
                  OP_DEL_END:   dec_ctrl.idx = last_idx;
                  default:      dec_ctrl.idx = pos_idx;
               endcase
               dec_count = count_ff - CNT_W'(1);
            end
         end
         OP_SEARCH, OP_UPDATE: begin
            if (empty) begin
               dec_res.status = ST_EMPTY;
            end else begin
               dec_scan = 1'b1;
            end
         end
         default: begin
            dec_res.status = ST_OK;
         end
      endcase
      dec_res.count = POS_W'(dec_count);
   end

   // ring scan: cell 0 holds entry step_ff
   assign match     = (cell_q[0] == val_ff) && !hit_ff;
   assign scan_hit  = hit_ff || match;
   assign scan_last = step_ff == (count_ff - CNT_W'(1));

   always_comb begin
      ctrl.kind = CELL_HOLD;
      ctrl.idx  = '0;
      ctrl.fill = cell_q[0];
      if (state_ff == SCAN) begin
         ctrl.kind = CELL_ROTATE;
         ctrl.idx  = last_idx;
         ctrl.fill = (match && upd_ff) ? nval_ff : cell_q[0];
      end else if (accept) begin
         ctrl = dec_ctrl;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      hit_in    = hit_ff;
      fpos_in   = fpos_ff;
      new_valid = 1'b0;
      new_res   = dec_res;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               count_in = dec_count;
               if (dec_scan) begin
                  state_in = SCAN;
                  step_in  = '0;
                  hit_in   = 1'b0;
                  fpos_in  = '0;
               end else begin
                  new_valid = 1'b1;
               end
            end
         end
         SCAN: begin
            if (match) begin
               hit_in  = 1'b1;
               fpos_in = CNT_W'(step_ff + CNT_W'(1));
            end
            step_in = step_ff + CNT_W'(1);
            if (scan_last) begin
               state_in       = IDLE;
               new_valid      = 1'b1;
               new_res.status = scan_hit ? ST_OK : ST_NOTFOUND;
               new_res.fpos   = POS_W'(fpos_in);
               new_res.count  = POS_W'(count_ff);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // two-word output stage
   always_comb begin
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      out_in         = out_ff;
      spare_in       = spare_ff;
      if (take) begin
         if (spare_valid_ff) begin
            out_in         = spare_ff;
            spare_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (new_valid) begin
         if (!out_valid_ff || (take && !spare_valid_ff)) begin
            out_in       = new_res;
            out_valid_in = 1'b1;
         end else begin
            spare_in       = new_res;
            spare_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         count_ff       <= '0;
         step_ff        <= '0;
         hit_ff         <= 1'b0;
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         step_ff        <= step_in;
         hit_ff         <= hit_in;
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      fpos_ff  <= fpos_in;
      out_ff   <= out_in;
      spare_ff <= spare_in;
      if (accept) begin
         val_ff  <= val;
         nval_ff <= nval;
         upd_ff  <= op == OP_UPDATE;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_head
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_q[i+1];
      end
      ole_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_q[i])
      );
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff.count, out_ff.fpos, out_ff.status};

endmodule
